// ----- src/stft_pkg.sv -----
package stft_pkg;

  // Field widths of the channels
  localparam int unsigned ROW_W      = 10;
  localparam int unsigned COL_W      = 6;
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned DROP_W     = 8;
  localparam int unsigned NROWS_W    = 11;
  localparam int unsigned NCOLS_W    = 7;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;

  // Register reset values
  localparam logic [NROWS_W-1:0] NUM_ROWS_RST = 11'd1024;
  localparam logic [NCOLS_W-1:0] NUM_COLS_RST = 7'd64;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_ROWS = 2'd0,
    CFG_NUM_COLS = 2'd1
  } cfg_idx_e;

  // One stored triplet
  typedef struct packed {
    logic        [ROW_W-1:0] row;
    logic        [COL_W-1:0] col;
    logic signed [VAL_W-1:0] value;
  } entry_t;

  // One result item
  typedef struct packed {
    logic        [COL_W-1:0]  out_row;
    logic        [ROW_W-1:0]  out_col;
    logic signed [VAL_W-1:0]  out_value;
    logic                     present;
    logic        [DROP_W-1:0] dropped_entries;
    logic                     last_result;
  } result_t;

endpackage

// ----- src/stft_if.sv -----
// Input triplet channel
interface stft_in_if;
  import stft_pkg::*;

  logic                    valid;
  logic                    ready;
  logic        [ROW_W-1:0] entry_row;
  logic        [COL_W-1:0] entry_col;
  logic signed [VAL_W-1:0] entry_value;
  logic                    is_last;

  modport source (output valid, entry_row, entry_col, entry_value, is_last, input ready);
  modport sink   (input valid, entry_row, entry_col, entry_value, is_last, output ready);
endinterface

// Result channel
interface stft_out_if;
  import stft_pkg::*;

  logic                     valid;
  logic                     ready;
  logic        [COL_W-1:0]  out_row;
  logic        [ROW_W-1:0]  out_col;
  logic signed [VAL_W-1:0]  out_value;
  logic                     present;
  logic        [DROP_W-1:0] dropped_entries;
  logic                     last_result;

  modport source (output valid, out_row, out_col, out_value, present, dropped_entries,
                  last_result, input ready);
  modport sink   (input valid, out_row, out_col, out_value, present, dropped_entries,
                  last_result, output ready);
endinterface

// Configuration write channel
interface stft_cfg_if;
  import stft_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/sparse_triplet_fast_transpose.sv -----
// Sparse matrix fast transpose.
// entry_i takes one triplet (row, column, value, is_last) per cycle while loading.
// Triplets out of range, or arriving with MAX_ENTRIES already stored, are dropped and
// counted (saturating at 255). cfg_i sets num_rows (index 0) and num_cols (index 1);
// it is always ready; the user must write it only while idle, as the block does not check.
// After the item marked last, entry_i is held off while the block runs:
//   prefix sums over the column count memory
//   scatter of the N stored entries into column-major order
//   clearing pass over the column memory
// then, while the receiver is ready, result_o gives the N transposed triplets at one
// per cycle from the transposed store, the final one marked last_result. With nothing
// stored a single result with present low is given instead, without the three phases.
// The column memory's single read port paces the scatter and counting steps.
// After reset the block runs the clearing pass before it first accepts an item. A
// stalled receiver holds the output register; the emitter then pauses and resumes
// without loss. The next matrix may start loading while the final result still waits
// in the output register.
module sparse_triplet_fast_transpose #(
  parameter int MAX_ENTRIES = 64,
  parameter int MAX_COLS    = 64,
  parameter int MAX_ROWS    = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  stft_cfg_if.sink   cfg_i,
  stft_in_if.sink    entry_i,
  stft_out_if.source result_o
);
  import stft_pkg::*;

  localparam int IW   = $clog2(MAX_ENTRIES);
  localparam int CNTW = $clog2(MAX_ENTRIES + 1);
  localparam int CIW  = $clog2(MAX_COLS);
  localparam logic [CNTW-1:0] MaxEntriesC = CNTW'(MAX_ENTRIES);
  localparam logic [CIW-1:0]  LastColC    = CIW'(MAX_COLS - 1);

  typedef enum logic [6:0] {
    ST_CLEAR   = 7'b0000001,
    ST_LOAD    = 7'b0000010,
    ST_PREFIX  = 7'b0000100,
    ST_SCATTER = 7'b0001000,
    ST_FLUSH   = 7'b0010000,
    ST_EMIT    = 7'b0100000,
    ST_EMPTY   = 7'b1000000
  } state_e;

  // Control registers
  state_e               state_q, state_d;
  logic [NROWS_W-1:0]   num_rows_q;
  logic [NCOLS_W-1:0]   num_cols_q;
  logic [CNTW-1:0]      stored_q, stored_d;
  logic [DROP_W-1:0]    dropped_q, dropped_d;
  logic [CIW-1:0]       sweep_q, sweep_d;
  logic [CNTW-1:0]      run_q, run_d;
  logic [CNTW-1:0]      idx_q, idx_d;
  logic                 p_valid_q, p_valid_d;
  logic [CIW-1:0]       p_col_q, p_col_d;
  logic                 e_valid_q, e_valid_d;
  logic                 b_valid_q, b_valid_d;
  logic                 b_scat_q, b_scat_d;
  logic [CIW-1:0]       b_col_q, b_col_d;
  entry_t               b_entry_q, b_entry_d;
  logic                 em_pend_q, em_pend_d;
  logic                 em_last_q, em_last_d;
  logic                 out_valid_q, out_valid_d;
  result_t              out_q, out_d;

  // Memories and their ports
  entry_t               entry_mem [MAX_ENTRIES];
  entry_t               trans_mem [MAX_ENTRIES];
  logic [CNTW-1:0]      col_mem   [MAX_COLS];
  entry_t               en_rd_q, tr_rd_q;
  logic [CNTW-1:0]      col_rd_q, fwd_data_q, col_val;
  logic                 fwd_hit_q;
  logic                 en_we, en_re, tr_we, tr_re, col_we, col_re;
  logic [IW-1:0]        en_raddr, tr_waddr, tr_raddr;
  logic [CIW-1:0]       col_waddr, col_raddr;
  logic [CNTW-1:0]      col_wdata;
  entry_t               in_entry;

  // Input checks
  logic                 in_acc, in_keep, can_load;
  logic [15:0]          in_col_ext, e_col_ext;
  logic [CIW-1:0]       in_col_idx, e_col_idx;

  assign cfg_i.ready   = 1'b1;
  assign entry_i.ready = (state_q == ST_LOAD);
  assign in_acc        = entry_i.valid && entry_i.ready;

  assign in_entry   = '{row: entry_i.entry_row, col: entry_i.entry_col,
                        value: entry_i.entry_value};
  assign in_col_ext = {10'b0, entry_i.entry_col};
  assign in_col_idx = in_col_ext[CIW-1:0];
  assign e_col_ext  = {10'b0, en_rd_q.col};
  assign e_col_idx  = e_col_ext[CIW-1:0];

  assign in_keep = ({1'b0, entry_i.entry_row} < num_rows_q)
                && (32'(entry_i.entry_row) < MAX_ROWS)
                && ({1'b0, entry_i.entry_col} < num_cols_q)
                && (32'(entry_i.entry_col) < MAX_COLS)
                && (stored_q < MaxEntriesC);

  // Column memory read, with the write of the same edge forwarded
  assign col_val = fwd_hit_q ? fwd_data_q : col_rd_q;

  assign can_load = !out_valid_q || result_o.ready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q <= NUM_ROWS_RST;
      num_cols_q <= NUM_COLS_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        CFG_NUM_ROWS: num_rows_q <= cfg_i.data[NROWS_W-1:0];
        CFG_NUM_COLS: num_cols_q <= cfg_i.data[NCOLS_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and memory port control
  always_comb begin
    state_d     = state_q;
    stored_d    = stored_q;
    dropped_d   = dropped_q;
    sweep_d     = sweep_q;
    run_d       = run_q;
    idx_d       = idx_q;
    p_valid_d   = 1'b0;
    p_col_d     = p_col_q;
    e_valid_d   = 1'b0;
    b_valid_d   = 1'b0;
    b_scat_d    = 1'b0;
    b_col_d     = b_col_q;
    b_entry_d   = b_entry_q;
    em_pend_d   = em_pend_q;
    em_last_d   = em_last_q;
    out_valid_d = out_valid_q && !result_o.ready;
    out_d       = out_q;

    en_we     = 1'b0;
    en_re     = 1'b0;
    en_raddr  = idx_q[IW-1:0];
    tr_we     = 1'b0;
    tr_waddr  = col_val[IW-1:0];
    tr_re     = 1'b0;
    tr_raddr  = idx_q[IW-1:0];
    col_we    = 1'b0;
    col_waddr = b_col_q;
    col_wdata = col_val + 1'b1;
    col_re    = 1'b0;
    col_raddr = in_col_idx;

    // Count update: in the cycle after the column read
    if (b_valid_q) begin
      col_we = 1'b1;
      tr_we  = b_scat_q;
    end

    // Prefix write: slot start of a column, running sum moves on
    if (p_valid_q) begin
      col_we    = 1'b1;
      col_waddr = p_col_q;
      col_wdata = run_q;
      run_d     = run_q + col_val;
    end

    case (state_q)
      ST_CLEAR, ST_FLUSH: begin
        col_we    = 1'b1;
        col_waddr = sweep_q;
        col_wdata = '0;
        sweep_d   = sweep_q + 1'b1;
        idx_d     = '0;
        em_pend_d = 1'b0;
        if (sweep_q == LastColC) begin
          sweep_d = '0;
          state_d = (stored_q != '0) ? ST_EMIT : ST_LOAD;
        end
      end

      ST_LOAD: begin
        if (in_acc) begin
          if (in_keep) begin
            en_we     = 1'b1;
            col_re    = 1'b1;
            b_valid_d = 1'b1;
            b_col_d   = in_col_idx;
            stored_d  = stored_q + 1'b1;
          end else if (dropped_q != {DROP_W{1'b1}}) begin
            dropped_d = dropped_q + 1'b1;
          end
          if (entry_i.is_last) begin
            sweep_d = '0;
            run_d   = '0;
            state_d = (stored_d == '0) ? ST_EMPTY : ST_PREFIX;
          end
        end
      end

      ST_PREFIX: begin
        col_re    = 1'b1;
        col_raddr = sweep_q;
        p_valid_d = 1'b1;
        p_col_d   = sweep_q;
        sweep_d   = sweep_q + 1'b1;
        if (sweep_q == LastColC) begin
          sweep_d = '0;
          idx_d   = '0;
          state_d = ST_SCATTER;
        end
      end

      ST_SCATTER: begin
        // Read stored entries in arrival order
        if (idx_q != stored_q) begin
          en_re     = 1'b1;
          e_valid_d = 1'b1;
          idx_d     = idx_q + 1'b1;
        end
        // Entry known: fetch its column's next slot
        if (e_valid_q) begin
          col_re    = 1'b1;
          col_raddr = e_col_idx;
          b_valid_d = 1'b1;
          b_scat_d  = 1'b1;
          b_col_d   = e_col_idx;
          b_entry_d = en_rd_q;
        end
        if (idx_q == stored_q && !e_valid_q && !b_valid_q) begin
          sweep_d = '0;
          state_d = ST_FLUSH;
        end
      end

      ST_EMIT: begin
        if (em_pend_q && can_load) begin
          out_valid_d = 1'b1;
          out_d = '{out_row: tr_rd_q.col, out_col: tr_rd_q.row, out_value: tr_rd_q.value,
                    present: 1'b1, dropped_entries: dropped_q, last_result: em_last_q};
          em_pend_d = 1'b0;
          if (em_last_q) begin
            stored_d  = '0;
            dropped_d = '0;
            state_d   = ST_LOAD;
          end
        end
        if (idx_q != stored_q && (!em_pend_q || can_load)) begin
          tr_re     = 1'b1;
          em_pend_d = 1'b1;
          em_last_d = (idx_q == stored_q - 1'b1);
          idx_d     = idx_q + 1'b1;
        end
      end

      ST_EMPTY: begin
        if (can_load) begin
          out_valid_d = 1'b1;
          out_d = '{out_row: '0, out_col: '0, out_value: '0, present: 1'b0,
                    dropped_entries: dropped_q, last_result: 1'b1};
          stored_d  = '0;
          dropped_d = '0;
          state_d   = ST_LOAD;
        end
      end

      default: state_d = ST_CLEAR;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      stored_q    <= '0;
      dropped_q   <= '0;
      sweep_q     <= '0;
      run_q       <= '0;
      idx_q       <= '0;
      p_valid_q   <= 1'b0;
      e_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      b_scat_q    <= 1'b0;
      em_pend_q   <= 1'b0;
      em_last_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      stored_q    <= stored_d;
      dropped_q   <= dropped_d;
      sweep_q     <= sweep_d;
      run_q       <= run_d;
      idx_q       <= idx_d;
      p_valid_q   <= p_valid_d;
      e_valid_q   <= e_valid_d;
      b_valid_q   <= b_valid_d;
      b_scat_q    <= b_scat_d;
      em_pend_q   <= em_pend_d;
      em_last_q   <= em_last_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    p_col_q   <= p_col_d;
    b_col_q   <= b_col_d;
    b_entry_q <= b_entry_d;
    out_q     <= out_d;
  end

  // Entry store: arrival order
  always_ff @(posedge clk_i) begin
    if (en_we) entry_mem[stored_q[IW-1:0]] <= in_entry;
    if (en_re) en_rd_q <= entry_mem[en_raddr];
  end

  // Transposed store: column-major order
  always_ff @(posedge clk_i) begin
    if (tr_we) trans_mem[tr_waddr] <= b_entry_q;
    if (tr_re) tr_rd_q <= trans_mem[tr_raddr];
  end

  // Column memory: counts, then next free slot per column
  always_ff @(posedge clk_i) begin
    if (col_we) col_mem[col_waddr] <= col_wdata;
    if (col_re) begin
      col_rd_q   <= col_mem[col_raddr];
      fwd_hit_q  <= col_we && (col_waddr == col_raddr);
      fwd_data_q <= col_wdata;
    end
  end

  // Result channel
  assign result_o.valid           = out_valid_q;
  assign result_o.out_row         = out_q.out_row;
  assign result_o.out_col         = out_q.out_col;
  assign result_o.out_value       = out_q.out_value;
  assign result_o.present         = out_q.present;
  assign result_o.dropped_entries = out_q.dropped_entries;
  assign result_o.last_result     = out_q.last_result;

endmodule
